/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VCR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/vcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vcr_pkg;

    localparam int MAX_ALT_DEF   = 64;
    localparam int MAX_CRIT_DEF  = 8;
    localparam int VALUE_BITS_DEF = 16;

    localparam int S_BITS = 22;
    localparam int R_BITS = 18;
    localparam int Q_BITS = 17;
    localparam int IDX_BITS = 6;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W = 32;

    localparam logic [Q_BITS-1:0] FRAC_ONE = 17'd65536;
    localparam logic [S_BITS-1:0] S_MAX = 22'd4194303;
    localparam logic [R_BITS-1:0] R_MAX = 18'd262143;

    localparam logic [CFG_IDX_W-1:0] CFG_ALT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTIONS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY   = 3'd4;

    localparam logic [1:0] DIR_LOWER  = 2'd0;
    localparam logic [1:0] DIR_HIGHER = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BW_RD,
        ST_BW_ACC,
        ST_SR_RD,
        ST_SR_X,
        ST_SR_DIV,
        ST_SR_WR,
        ST_Q_RD,
        ST_Q_LD,
        ST_Q_DS,
        ST_Q_DR,
        ST_EM_RD,
        ST_EM_CMP,
        ST_EM_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              mark;
        logic [Q_BITS-1:0] q;
        logic [R_BITS-1:0] r;
        logic [S_BITS-1:0] s;
    } score_entry_t;

endpackage
`default_nettype wire

/* rtl/vcr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module vcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/vcr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module vcr_div (
    input  logic                    clk,
    input  logic                    rstn,
    input  vcr_pkg::div_req_t       req,
    output logic                    done,
    output logic [vcr_pkg::Q_BITS-1:0] quo
);
    import vcr_pkg::*;

    // Restoring division of num * 2^16 by den, one quotient bit a cycle.
    // The numerator never exceeds the divisor, so seventeen bits suffice.
    logic [DIV_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [Q_BITS-1:0] q_reg, q_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;
    logic [DIV_W:0]    diff;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge   = rem_reg >= {1'b0, den_reg};
        diff = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        if (busy_reg) begin
            q_next   = {q_reg[Q_BITS-2:0], ge};
            rem_next = {diff[DIV_W-1:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            q_next    = '0;
            cnt_next  = 5'(Q_BITS - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    // A zero divisor marks a flat or ignored quantity: the ratio is zero.
    assign done = done_reg;
    assign quo  = (den_reg == '0) ? '0 : q_reg;

endmodule
`default_nettype wire

/* rtl/vikor_compromise_ranking.sv */
// A load item is written in the cycle it is accepted, one load item per cycle while the
// sequencer idles. A compute item uses the shared divider once per score and twice per Q,
// and each memory has a single read port. Results wait for the consumer.
// Reset (aresetn low, synchronous) clears control state and restores register defaults;
// the value matrix holds no defined contents until loaded.
`timescale 1ns / 1ps
`default_nettype none
module vikor_compromise_ranking #(
    parameter int MAX_ALTERNATIVES = vcr_pkg::MAX_ALT_DEF,
    parameter int MAX_CRITERIA     = vcr_pkg::MAX_CRIT_DEF,
    parameter int VALUE_BITS       = vcr_pkg::VALUE_BITS_DEF,
    localparam int S_TDATA_W = ((9 + VALUE_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // alt_index [5:0], crit_index [8:6], value [8+VALUE_BITS:9], zero fill above
    input  logic [S_TDATA_W-1:0]             s_tdata,
    // opcode: 0 load one value, 1 compute and emit the ranking
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ranked_alternative [5:0], group_utility [27:6], individual_regret [45:28],
    // compromise_index [62:46], zero at bit 63
    output logic [vcr_pkg::M_TDATA_W-1:0]    m_tdata,
    // last_of_ranking
    output logic                             m_tlast,
    input  logic                             cfg_wen,
    input  logic [vcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import vcr_pkg::*;

    localparam int ALT_W  = $clog2(MAX_ALTERNATIVES);
    localparam int CRIT_W = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1;
    localparam int MAT_DEPTH = MAX_ALTERNATIVES << CRIT_W;
    localparam int ENTRY_W = $bits(score_entry_t);

    // Configuration registers.
    logic [6:0]  alt_count_reg;
    logic [3:0]  crit_count_reg;
    logic [15:0] dir_reg;
    logic [63:0] weight_reg;
    logic [8:0]  v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_count_reg  <= 7'd1;
            crit_count_reg <= 4'd1;
            dir_reg        <= '0;
            weight_reg     <= '0;
            v_reg          <= 9'd128;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_ALT_COUNT:  alt_count_reg  <= cfg_wdata[6:0];
                CFG_CRIT_COUNT: crit_count_reg <= cfg_wdata[3:0];
                CFG_DIRECTIONS: dir_reg        <= cfg_wdata[15:0];
                CFG_WEIGHTS:    weight_reg     <= cfg_wdata;
                CFG_STRATEGY:   v_reg          <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Counts in use: zero acts as one and large values saturate to the storage size.
    logic [ALT_W:0]  na;
    logic [CRIT_W:0] nc;
    logic [8:0]      v_sat;

    always_comb begin
        if (alt_count_reg == '0) begin
            na = (ALT_W + 1)'(1);
        end else if (32'(alt_count_reg) > MAX_ALTERNATIVES) begin
            na = (ALT_W + 1)'(MAX_ALTERNATIVES);
        end else begin
            na = (ALT_W + 1)'(alt_count_reg);
        end
        if (crit_count_reg == '0) begin
            nc = (CRIT_W + 1)'(1);
        end else if (32'(crit_count_reg) > MAX_CRITERIA) begin
            nc = (CRIT_W + 1)'(MAX_CRITERIA);
        end else begin
            nc = (CRIT_W + 1)'(crit_count_reg);
        end
        v_sat = (v_reg > 9'd256) ? 9'd256 : v_reg;
    end

    // Input item fields.
    logic [5:0]            in_alt;
    logic [2:0]            in_crit;
    logic [VALUE_BITS-1:0] in_value;
    assign in_alt   = s_tdata[5:0];
    assign in_crit  = s_tdata[8:6];
    assign in_value = s_tdata[8+VALUE_BITS:9];

    // The value matrix lives in one RAM, addressed by row and column; loads write it
    // directly while the sequencer idles.
    logic                    mat_we;
    logic [ALT_W+CRIT_W-1:0] mat_waddr, mat_raddr;
    logic [VALUE_BITS-1:0]   mat_rdata;

    logic [ALT_W-1:0]  a_reg, a_next;
    logic [CRIT_W-1:0] c_reg, c_next;

    assign mat_we = s_tvalid && s_tready && !s_tuser
                    && (32'(in_alt) < MAX_ALTERNATIVES) && (32'(in_crit) < MAX_CRITERIA);
    assign mat_waddr = {ALT_W'(in_alt), CRIT_W'(in_crit)};
    assign mat_raddr = {a_reg, c_reg};

    vcr_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_matrix (
        .clk   (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (in_value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // S, R, Q and the emitted mark of every alternative share a second RAM, one entry
    // per row. The mark is written at the picked row when its result is sent.
    logic             sc_we;
    logic [ALT_W-1:0] sc_waddr;
    score_entry_t     sc_wdata, sc_rdata;

    vcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ALTERNATIVES)
    ) u_scores (
        .clk   (aclk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (a_reg),
        .rdata (sc_rdata)
    );

    // One shared divider serves the fractions and both normalised terms of Q.
    div_req_t          div_req;
    logic              div_done;
    logic [Q_BITS-1:0] div_quo;

    vcr_div u_div (
        .clk  (aclk),
        .rstn (aresetn),
        .req  (div_req),
        .done (div_done),
        .quo  (div_quo)
    );

    // Sequencer state.
    state_t                state_reg, state_next;
    logic [ALT_W-1:0]      k_reg, k_next;
    logic [VALUE_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [VALUE_BITS-1:0] best_reg [MAX_CRITERIA];
    logic [VALUE_BITS-1:0] best_next [MAX_CRITERIA];
    logic [VALUE_BITS-1:0] worst_reg [MAX_CRITERIA];
    logic [VALUE_BITS-1:0] worst_next [MAX_CRITERIA];
    logic [S_BITS-1:0]     s_reg, s_next, mins_reg, mins_next, maxs_reg, maxs_next;
    logic [R_BITS-1:0]     r_reg, r_next, minr_reg, minr_next, maxr_reg, maxr_next;
    logic [Q_BITS-1:0]     st_reg, st_next;
    logic                  found_reg, found_next;
    logic [ALT_W-1:0]      pick_reg, pick_next;
    score_entry_t          pick_e_reg, pick_e_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  a_last, c_last;
    logic [1:0]            dir;
    logic [7:0]            wgt;
    logic [VALUE_BITS-1:0] lo_n, hi_n, bst, wst, x;
    logic [24:0]           prod;
    logic [R_BITS:0]       score;
    logic [S_BITS:0]       ssum;
    logic [25:0]           pv, pr;
    logic [26:0]           qsum;
    logic [18:0]           qsh;
    logic [Q_BITS-1:0]     qv;

    assign a_last = ({1'b0, a_reg} == na - 1'b1);
    assign c_last = ({1'b0, c_reg} == nc - 1'b1);
    assign dir    = dir_reg[{c_reg, 1'b0} +: 2];
    assign wgt    = weight_reg[{c_reg, 3'b000} +: 8];
    assign x      = mat_rdata;
    assign bst    = best_reg[c_reg];
    assign wst    = worst_reg[c_reg];

    always_comb begin
        state_next  = state_reg;
        a_next      = a_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        best_next   = best_reg;
        worst_next  = worst_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        mins_next   = mins_reg;
        maxs_next   = maxs_reg;
        minr_next   = minr_reg;
        maxr_next   = maxr_reg;
        st_next     = st_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        pick_e_next = pick_e_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        sc_we       = 1'b0;
        sc_waddr    = a_reg;
        sc_wdata    = '0;
        div_req     = '0;
        lo_n  = (x < lo_reg) ? x : lo_reg;
        hi_n  = (x > hi_reg) ? x : hi_reg;
        prod  = 25'(div_quo) * 25'(wgt);
        score = 19'(prod >> 6);
        if (score > {1'b0, R_MAX}) begin
            score = {1'b0, R_MAX};
        end
        ssum = {1'b0, s_reg} + 23'(score);
        pv   = 26'(v_sat) * 26'(st_reg);
        pr   = 26'(9'd256 - v_sat) * 26'(div_quo);
        qsum = 27'(pv) + 27'(pr);
        qsh  = qsum[26:8];
        qv   = (qsh > 19'(FRAC_ONE)) ? FRAC_ONE : qsh[Q_BITS-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser) begin
                    a_next = '0;
                    c_next = '0;
                    state_next = ST_BW_RD;
                end
            end
            ST_BW_RD: begin
                state_next = ST_BW_ACC;
            end
            ST_BW_ACC: begin
                if (a_reg == '0) begin
                    lo_n = x;
                    hi_n = x;
                end
                lo_next = lo_n;
                hi_next = hi_n;
                if (a_last) begin
                    if (dir == DIR_LOWER) begin
                        best_next[c_reg]  = lo_n;
                        worst_next[c_reg] = hi_n;
                    end else if (dir == DIR_HIGHER) begin
                        best_next[c_reg]  = hi_n;
                        worst_next[c_reg] = lo_n;
                    end else begin
                        best_next[c_reg]  = '0;
                        worst_next[c_reg] = '0;
                    end
                    a_next = '0;
                    if (c_last) begin
                        c_next = '0;
                        s_next = '0;
                        r_next = '0;
                        state_next = ST_SR_RD;
                    end else begin
                        c_next = c_reg + 1'b1;
                        state_next = ST_BW_RD;
                    end
                end else begin
                    a_next = a_reg + 1'b1;
                    state_next = ST_BW_RD;
                end
            end
            ST_SR_RD: begin
                state_next = ST_SR_X;
            end
            ST_SR_X: begin
                // An ignored criterion divides by zero, which the divider returns as zero.
                div_req.start = 1'b1;
                div_req.num = DIV_W'((bst > x) ? bst - x : x - bst);
                div_req.den = (dir == DIR_LOWER || dir == DIR_HIGHER)
                              ? DIV_W'((bst > wst) ? bst - wst : wst - bst) : '0;
                state_next = ST_SR_DIV;
            end
            ST_SR_DIV: begin
                if (div_done) begin
                    s_next = (ssum > {1'b0, S_MAX}) ? S_MAX : ssum[S_BITS-1:0];
                    if (score[R_BITS-1:0] > r_reg) begin
                        r_next = score[R_BITS-1:0];
                    end
                    if (c_last) begin
                        state_next = ST_SR_WR;
                    end else begin
                        c_next = c_reg + 1'b1;
                        state_next = ST_SR_RD;
                    end
                end
            end
            ST_SR_WR: begin
                sc_we = 1'b1;
                sc_wdata.s = s_reg;
                sc_wdata.r = r_reg;
                sc_wdata.q = '0;
                if (a_reg == '0 || s_reg < mins_reg) mins_next = s_reg;
                if (a_reg == '0 || s_reg > maxs_reg) maxs_next = s_reg;
                if (a_reg == '0 || r_reg < minr_reg) minr_next = r_reg;
                if (a_reg == '0 || r_reg > maxr_reg) maxr_next = r_reg;
                s_next = '0;
                r_next = '0;
                c_next = '0;
                if (a_last) begin
                    a_next = '0;
                    state_next = ST_Q_RD;
                end else begin
                    a_next = a_reg + 1'b1;
                    state_next = ST_SR_RD;
                end
            end
            ST_Q_RD: begin
                state_next = ST_Q_LD;
            end
            ST_Q_LD: begin
                s_next = sc_rdata.s;
                r_next = sc_rdata.r;
                div_req.start = 1'b1;
                div_req.num = DIV_W'(sc_rdata.s - mins_reg);
                div_req.den = DIV_W'(maxs_reg - mins_reg);
                state_next = ST_Q_DS;
            end
            ST_Q_DS: begin
                if (div_done) begin
                    st_next = div_quo;
                    div_req.start = 1'b1;
                    div_req.num = DIV_W'(r_reg - minr_reg);
                    div_req.den = DIV_W'(maxr_reg - minr_reg);
                    state_next = ST_Q_DR;
                end
            end
            ST_Q_DR: begin
                if (div_done) begin
                    // The entry is rewritten with its mark clear for the ranking run.
                    sc_we = 1'b1;
                    sc_wdata.s = s_reg;
                    sc_wdata.r = r_reg;
                    sc_wdata.q = qv;
                    sc_wdata.mark = 1'b0;
                    if (a_last) begin
                        a_next = '0;
                        k_next = '0;
                        found_next = 1'b0;
                        state_next = ST_EM_RD;
                    end else begin
                        a_next = a_reg + 1'b1;
                        state_next = ST_Q_RD;
                    end
                end
            end
            ST_EM_RD: begin
                state_next = ST_EM_CMP;
            end
            ST_EM_CMP: begin
                // Strict comparison keeps the lower index on a tie.
                if (!sc_rdata.mark && (!found_reg || sc_rdata.q < pick_e_reg.q)) begin
                    pick_next   = a_reg;
                    pick_e_next = sc_rdata;
                    found_next  = 1'b1;
                end
                if (a_last) begin
                    state_next = ST_EM_OUT;
                end else begin
                    a_next = a_reg + 1'b1;
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, pick_e_reg.q, pick_e_reg.r, pick_e_reg.s,
                                    IDX_BITS'(pick_reg)};
                    m_last_next  = ({1'b0, k_reg} == na - 1'b1);
                    // The picked row is marked so that later scans pass over it.
                    sc_we = 1'b1;
                    sc_waddr = pick_reg;
                    sc_wdata = pick_e_reg;
                    sc_wdata.mark = 1'b1;
                    found_next = 1'b0;
                    a_next = '0;
                    if ({1'b0, k_reg} == na - 1'b1) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            for (int i = 0; i < MAX_CRITERIA; i++) begin
                best_reg[i]  <= '0;
                worst_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            best_reg    <= best_next;
            worst_reg   <= worst_next;
        end
        a_reg      <= a_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        s_reg      <= s_next;
        r_reg      <= r_next;
        mins_reg   <= mins_next;
        maxs_reg   <= maxs_next;
        minr_reg   <= minr_next;
        maxr_reg   <= maxr_next;
        st_reg     <= st_next;
        pick_reg   <= pick_next;
        pick_e_reg <= pick_e_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // Items are taken only while the sequencer idles; the output register keeps the
    // last result on offer independently of that.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

/* rtl/vcr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vcr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vcr_pkg::M_TDATA_W-1:0] m_tdata
);
    import vcr_pkg::*;

    `VCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `VCR_ASSERT_NEXT(a_compute_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready)
    `VCR_ASSERT_NEXT(a_load_ready, aclk, aresetn, s_tvalid && s_tready && !s_tuser, s_tready)
    `VCR_ASSERT_NOW(a_q_range, aclk, aresetn, m_tvalid, m_tdata[62:46] <= FRAC_ONE && !m_tdata[63])

endmodule

bind vikor_compromise_ranking vcr_checker u_vcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
